// ===== sv/s3tc_block_decoder_assert.svh =====
`ifndef S3TC_BLOCK_DECODER_ASSERT_SVH
`define S3TC_BLOCK_DECODER_ASSERT_SVH

// same-cycle implication
`define S3TC_ASSERT_IMP(lbl, clk, dis, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define S3TC_ASSERT_NXT(lbl, clk, dis, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/s3tc_pkg.sv =====
package s3tc_pkg;

   localparam int COLOR_W         = 64;
   localparam int ALPHA_W         = 64;
   localparam int REQ_TDATA_W     = COLOR_W + ALPHA_W;
   localparam int CHAN_W          = 8;
   localparam int POS_W           = 4;
   localparam int POS_LSB         = 4 * CHAN_W;
   localparam int RSP_FIELDS_W    = POS_LSB + POS_W;
   localparam int RSP_TDATA_W     = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int FMT_W           = 2;
   localparam int QUEUE_DEPTH_DEF = 2;

   localparam logic [10:0] CHAN_MAX = 11'd255;
   localparam logic [21:0] RECIP3   = 22'd683;
   localparam logic [21:0] RECIP5   = 22'd1639;
   localparam logic [21:0] RECIP7   = 22'd2341;

   typedef enum logic [FMT_W-1:0] {
      FMT_BC1 = 2'd0,
      FMT_BC2 = 2'd1,
      FMT_BC3 = 2'd2
   } fmt_type;

   typedef enum logic [2:0] {
      DIV_1,
      DIV_2,
      DIV_3,
      DIV_5,
      DIV_7
   } div_type;

   typedef struct packed {
      logic [COLOR_W-1:0] color_half;
      logic [ALPHA_W-1:0] alpha_half;
      fmt_type            fmt;
      logic               three_colour;
      logic               six_level;
   } blk_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rgb_type;

   function automatic rgb_type expand565(input logic [15:0] v);
      rgb_type c;
      c.red   = {v[15:11], v[15:13]};
      c.green = {v[10:5], v[10:9]};
      c.blue  = {v[4:0], v[4:2]};
      return c;
   endfunction

   // truncating divide of a palette sum by a small constant
   function automatic logic [CHAN_W-1:0] div_const(input logic [10:0] num,
                                                   input div_type    kind);
      logic [21:0] prod3;
      logic [21:0] prod5;
      logic [21:0] prod7;
      logic [CHAN_W-1:0] q;
      prod3 = 22'(num) * RECIP3;
      prod5 = 22'(num) * RECIP5;
      prod7 = 22'(num) * RECIP7;
      case (kind)
         DIV_1:   q = num[7:0];
         DIV_2:   q = num[8:1];
         DIV_3:   q = prod3[18:11];
         DIV_5:   q = prod5[20:13];
         DIV_7:   q = prod7[21:14];
         default: q = num[7:0];
      endcase
      return q;
   endfunction

endpackage

// ===== sv/s3tc_front.sv =====
module s3tc_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [s3tc_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic                               csr_wen,
   input  logic [s3tc_pkg::FMT_W-1:0]         csr_wdata,
   output logic                               push_valid,
   output s3tc_pkg::blk_type                  push_item,
   input  logic                               push_ready
);
   import s3tc_pkg::*;

   fmt_type fmt_ff, fmt_in;
   logic    valid_ff, valid_in;
   blk_type item_ff, item_in;
   logic    accept;

   assign req_tready = !valid_ff || push_ready;
   assign accept     = req_tvalid && req_tready;
   assign push_valid = valid_ff;
   assign push_item  = item_ff;

   always_comb begin
      fmt_in = fmt_ff;
      if (csr_wen) begin
         case (csr_wdata)
            2'd0:    fmt_in = FMT_BC1;
            2'd1:    fmt_in = FMT_BC2;
            default: fmt_in = FMT_BC3;
         endcase
      end
   end

   // classify the block against the current format
   always_comb begin
      item_in.color_half   = req_tdata[COLOR_W-1:0];
      item_in.alpha_half   = req_tdata[REQ_TDATA_W-1:COLOR_W];
      item_in.fmt          = fmt_ff;
      item_in.three_colour = (fmt_ff == FMT_BC1) &&
                             (req_tdata[15:0] <= req_tdata[31:16]);
      item_in.six_level    = req_tdata[COLOR_W+7:COLOR_W] <=
                             req_tdata[COLOR_W+15:COLOR_W+8];
      valid_in = accept || (valid_ff && !push_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff   <= FMT_BC1;
         valid_ff <= 1'b0;
      end else begin
         fmt_ff   <= fmt_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

// ===== sv/s3tc_queue.sv =====
module s3tc_queue #(
   parameter int Depth = s3tc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  s3tc_pkg::blk_type push_item,
   output logic              pop_valid,
   input  logic              pop,
   output s3tc_pkg::blk_type pop_item
);
   import s3tc_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   blk_type         mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign push_ready = count_ff != CntW'(Depth);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== sv/s3tc_back.sv =====
module s3tc_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               pop_valid,
   output logic                               pop,
   input  s3tc_pkg::blk_type                  pop_item,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [s3tc_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                               rsp_tlast
);
   import s3tc_pkg::*;

   logic [POS_W-1:0]       cnt_ff, cnt_in;
   logic                   advance;

   logic [2:0][CHAN_W-1:0] e0, e1;
   logic [1:0]             ci;
   logic [3:0]             a4;
   logic [2:0]             a3;
   logic [2:0]             w;
   logic [CHAN_W-1:0]      a0, a1;
   logic [2:0][9:0]        col_num;
   div_type                col_div;
   logic [10:0]            alp_num;
   div_type                alp_div;

   logic                   s1_valid_ff;
   logic [POS_W-1:0]       s1_pos_ff;
   logic [2:0][9:0]        s1_col_num_ff;
   div_type                s1_col_div_ff;
   logic [10:0]            s1_alp_num_ff;
   div_type                s1_alp_div_ff;

   logic                   out_valid_ff;
   logic [POS_W-1:0]       out_pos_ff;
   logic [2:0][CHAN_W-1:0] out_col_ff;
   logic [CHAN_W-1:0]      out_alp_ff;

   assign advance = !out_valid_ff || rsp_tready;
   assign pop     = advance && pop_valid && (cnt_ff == '1);
   assign cnt_in  = (advance && pop_valid) ? cnt_ff + 1'b1 : cnt_ff;

   // palette entry for the current texel, ahead of the divide
   always_comb begin
      e0 = expand565(pop_item.color_half[15:0]);
      e1 = expand565(pop_item.color_half[31:16]);
      ci = 2'(pop_item.color_half[63:32] >> {cnt_ff, 1'b0});
      a4 = 4'(pop_item.alpha_half >> {cnt_ff, 2'b00});
      a3 = 3'(pop_item.alpha_half[63:16] >> ({2'b00, cnt_ff} + {1'b0, cnt_ff, 1'b0}));
      w  = 3'(a3 - 3'd1);
      a0 = pop_item.alpha_half[7:0];
      a1 = pop_item.alpha_half[15:8];

      col_div = DIV_1;
      if (ci == 2'd2) begin
         col_div = pop_item.three_colour ? DIV_2 : DIV_3;
      end else if (ci == 2'd3 && !pop_item.three_colour) begin
         col_div = DIV_3;
      end
      for (int k = 0; k < 3; k++) begin
         case (ci)
            2'd0: col_num[k] = 10'(e0[k]);
            2'd1: col_num[k] = 10'(e1[k]);
            2'd2: col_num[k] = pop_item.three_colour ? 10'(e0[k]) + 10'(e1[k])
                                                     : {1'b0, e0[k], 1'b0} + 10'(e1[k]);
            2'd3: col_num[k] = pop_item.three_colour ? 10'd0
                                                     : 10'(e0[k]) + {1'b0, e1[k], 1'b0};
            default: col_num[k] = 10'd0;
         endcase
      end

      alp_div = DIV_1;
      case (pop_item.fmt)
         FMT_BC1: begin
            alp_num = (pop_item.three_colour && ci == 2'd3) ? 11'd0 : CHAN_MAX;
         end
         FMT_BC2: begin
            alp_num = 11'({a4, a4});
         end
         default: begin
            if (a3 == 3'd0) begin
               alp_num = 11'(a0);
            end else if (a3 == 3'd1) begin
               alp_num = 11'(a1);
            end else if (!pop_item.six_level) begin
               alp_num = 11'(a0) * 11'(3'(3'd7 - w)) + 11'(a1) * 11'(w);
               alp_div = DIV_7;
            end else if (a3 == 3'd6) begin
               alp_num = 11'd0;
            end else if (a3 == 3'd7) begin
               alp_num = CHAN_MAX;
            end else begin
               alp_num = 11'(a0) * 11'(3'(3'd5 - w)) + 11'(a1) * 11'(w);
               alp_div = DIV_5;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (advance) begin
            s1_valid_ff  <= pop_valid;
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_pos_ff     <= cnt_ff;
         s1_col_num_ff <= col_num;
         s1_col_div_ff <= col_div;
         s1_alp_num_ff <= alp_num;
         s1_alp_div_ff <= alp_div;
         out_pos_ff    <= s1_pos_ff;
         out_alp_ff    <= div_const(s1_alp_num_ff, s1_alp_div_ff);
         for (int k = 0; k < 3; k++) begin
            out_col_ff[k] <= div_const(11'(s1_col_num_ff[k]), s1_col_div_ff);
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_pos_ff == '1;
   assign rsp_tdata  = {(RSP_TDATA_W - RSP_FIELDS_W)'(0), out_pos_ff, out_alp_ff,
                        out_col_ff[0], out_col_ff[1], out_col_ff[2]};

endmodule

// ===== sv/s3tc_block_decoder.sv =====
// S3TC block decoder. Each beat in carries one 4x4 block (colour half in the
// low 64 bits, alpha half in the high 64) and yields sixteen RGBA8 texel beats
// in row-major order, the sixteenth marked by rsp_tlast. The format register
// (0 BC1, 1 BC2, 2 or 3 BC3) is sampled when a block is taken and may be
// written only while the decoder is idle. Texels leave at one per cycle while
// rsp_tready is held high; the texel counter of the back end, which walks one
// palette lookup and divide per cycle, sets that rate. A new block can be taken
// while the previous one is still being emitted, through a front register and
// a QueueDepth-entry queue. Each texel then passes the s1 and output registers
// of the back end before it leaves.
module s3tc_block_decoder #(
   parameter int QueueDepth = s3tc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [s3tc_pkg::REQ_TDATA_W-1:0]   req_tdata,  // color_half, alpha_half
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [s3tc_pkg::RSP_TDATA_W-1:0]   rsp_tdata,  // red, green, blue, alpha,
                                                          // texel_position, zero pad
   output logic                               rsp_tlast,
   input  logic                               csr_wen,
   input  logic [s3tc_pkg::FMT_W-1:0]         csr_wdata
);
   import s3tc_pkg::*;

   logic    push_valid, push_ready;
   blk_type push_item;
   logic    pop_valid, pop;
   blk_type pop_item;

   s3tc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   s3tc_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_item   (pop_item)
   );

   s3tc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_item   (pop_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== sv/s3tc_checker.sv =====
`include "s3tc_block_decoder_assert.svh"

module s3tc_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [s3tc_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input logic                               rsp_tlast
);
   import s3tc_pkg::*;

   logic [POS_W-1:0] exp_pos_ff;
   logic [POS_W-1:0] pos;

   assign pos = rsp_tdata[POS_LSB +: POS_W];

   // track the texel number the next beat must carry
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_pos_ff <= '0;
      end else if (rsp_tvalid && rsp_tready) begin
         exp_pos_ff <= exp_pos_ff + 1'b1;
      end
   end

   `S3TC_ASSERT_NXT(a_ready_after_reset, clock, 1'b0, reset, req_tready, "input not ready after reset")
   `S3TC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "stalled texel beat changed")
   `S3TC_ASSERT_IMP(a_pos_order, clock, reset, rsp_tvalid, pos == exp_pos_ff, "texel out of order")
   `S3TC_ASSERT_IMP(a_last_mark, clock, reset, rsp_tvalid, rsp_tlast == (pos == 4'hF), "last mark misplaced")

endmodule

bind s3tc_block_decoder s3tc_checker u_s3tc_checker (.*);
